// ===== design/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and codes for the searchable lifo stack: beat payloads,
// operation and status codes, and the per-cell shift control.
// ----------------------------------------------------------------------------
package lss_pkg;

  // operation codes
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int WORD_W = 32;
  localparam int POS_W  = 6;
  localparam int OCC_W  = 7;

  // input beat
  typedef struct packed {
    logic [1:0]               mode;
    logic signed [WORD_W-1:0] value;
  } in_t;

  // result beat
  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
  } out_t;

  // shift control broadcast to every cell
  typedef struct packed {
    logic push;  // every cell takes the word from the cell above
    logic pop;   // every cell takes the word from the cell below
  } cell_ctl_t;

endpackage

// ===== design/lifo_stack_with_search.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded lifo stack of signed 32-bit words with push, pop, search and
// clear; held as a row of shifting cells with the top in cell 0.
// ----------------------------------------------------------------------------
//
//  channel | ports                    | payload
//  --------+--------------------------+------------------------------------
//  input   | in_valid / in_ready      | in_data  : mode, value
//  result  | out_valid / out_ready    | out_data : status, found, position,
//          |                          |            occupancy
//
//  one beat per cycle unless a result stalls: every cell compares and
//  shifts in parallel, and the result lands in the output register at the same edge.
//  a new beat is taken while the result register is empty or being drained.
//  reset clears the fill count and the result valid flag; cell words are
//  left as they are and are never read above the fill level.
//  a stalled result holds its register and blocks the input side.
//
module lifo_stack_with_search #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lss_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lss_pkg::out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  lss_pkg::out_t          out_data_r;
  lss_pkg::out_t          out_data_nxt;
  lss_pkg::cell_ctl_t     ctl;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic [DEPTH-1:0]       live;
  logic [DEPTH-1:0]       hit_vec;
  logic                   any_hit;
  logic [PW-1:0]          hit_pos;
  logic signed [lss_pkg::WORD_W-1:0] cell_data [DEPTH];

  assign accept = in_valid && in_ready;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  // cell row, cell 0 is the top of the stack
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [lss_pkg::WORD_W-1:0] above;
    logic signed [lss_pkg::WORD_W-1:0] below;

    if (k == 0) begin : g_top
      assign above = in_data.value;
    end else begin : g_mid
      assign above = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_bot
      assign below = cell_data[k];
    end else begin : g_nbot
      assign below = cell_data[k+1];
    end

    assign live[k] = (count_r > CW'(k));

    lss_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .above_i (above),
      .below_i (below),
      .key_i   (in_data.value),
      .live_i  (live[k]),
      .data_o  (cell_data[k]),
      .hit_o   (hit_vec[k])
    );
  end

  // nearest-to-top match
  lss_prio #(.DEPTH(DEPTH)) u_prio (
    .hit_vec (hit_vec),
    .any_o   (any_hit),
    .pos_o   (hit_pos)
  );

  // operation decode
  always_comb begin
    ctl                    = '0;
    count_nxt              = count_r;
    out_data_nxt           = out_data_r;
    if (accept) begin
      out_data_nxt.status   = lss_pkg::ST_OK;
      out_data_nxt.found    = 1'b0;
      out_data_nxt.position = '0;
      unique case (in_data.mode)
        lss_pkg::MODE_PUSH: begin
          if (full) begin
            out_data_nxt.status = lss_pkg::ST_FULL;
          end else begin
            ctl.push  = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        lss_pkg::MODE_POP: begin
          if (empty) begin
            out_data_nxt.status = lss_pkg::ST_EMPTY;
          end else begin
            ctl.pop   = 1'b1;
            count_nxt = count_r - CW'(1);
          end
        end
        lss_pkg::MODE_SEARCH: begin
          out_data_nxt.found = any_hit;
          if (any_hit) begin
            out_data_nxt.position = lss_pkg::POS_W'(hit_pos);
          end
        end
        lss_pkg::MODE_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
      out_data_nxt.occupancy = lss_pkg::OCC_W'(count_nxt);
    end
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/lss_cell.sv =====
// ----------------------------------------------------------------------------
// lss_cell
// One stack entry: holds a word, shifts down on push and up on pop, and
// compares its word against the search key.
// ----------------------------------------------------------------------------
module lss_cell (
  input  logic                                 clk,
  input  lss_pkg::cell_ctl_t                   ctl,
  input  logic signed [lss_pkg::WORD_W-1:0]    above_i,
  input  logic signed [lss_pkg::WORD_W-1:0]    below_i,
  input  logic signed [lss_pkg::WORD_W-1:0]    key_i,
  input  logic                                 live_i,
  output logic signed [lss_pkg::WORD_W-1:0]    data_o,
  output logic                                 hit_o
);

  logic signed [lss_pkg::WORD_W-1:0] data_r;
  logic signed [lss_pkg::WORD_W-1:0] data_nxt;

  // pick the neighbor to load from
  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      data_nxt = above_i;
    end else if (ctl.pop) begin
      data_nxt = below_i;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // match only counts for entries below the fill level
  assign hit_o  = live_i && (data_r == key_i);
  assign data_o = data_r;

endmodule

// ===== design/lss_prio.sv =====
// ----------------------------------------------------------------------------
// lss_prio
// Priority encoder over the cell match vector: the lowest index (nearest
// the top) wins.
// ----------------------------------------------------------------------------
module lss_prio #(
  parameter int DEPTH = 64
) (
  input  logic [DEPTH-1:0]         hit_vec,
  output logic                     any_o,
  output logic [$clog2(DEPTH)-1:0] pos_o
);

  localparam int PW = $clog2(DEPTH);

  logic [DEPTH-1:0] first_hit;

  // isolate the lowest set bit
  assign first_hit = hit_vec & (~hit_vec + DEPTH'(1));
  assign any_o     = |hit_vec;

  // encode the one-hot hit, one output bit at a time
  always_comb begin
    pos_o = '0;
    for (int b = 0; b < PW; b++) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (((k >> b) & 1) == 1) begin
          pos_o[b] = pos_o[b] | first_hit[k];
        end
      end
    end
  end

endmodule

// ===== design/lss_chk.sv =====
// ----------------------------------------------------------------------------
// lss_chk
// Port-level checks for the searchable lifo stack, bound to the top level.
// ----------------------------------------------------------------------------
module lss_chk #(
  parameter int DEPTH = 64
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input lss_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input lss_pkg::out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a dropped push only happens at the full level
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == lss_pkg::ST_FULL)
      |-> out_data.occupancy == lss_pkg::OCC_W'(DEPTH))
    else $error("push flagged full below capacity");

  // an ignored pop leaves the stack empty
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == lss_pkg::ST_EMPTY)
      |-> out_data.occupancy == '0)
    else $error("pop flagged empty with entries held");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.position == '0)
    else $error("position set without a hit");

  // a taken clear beat comes back with an empty stack
  a_clear_occ: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == lss_pkg::MODE_CLEAR)
      |=> out_valid && (out_data.occupancy == '0))
    else $error("clear left entries held");

endmodule

bind lifo_stack_with_search lss_chk #(.DEPTH(DEPTH)) u_lss_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/lifo_stack_with_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search_tb
// Drives push, pop, search and clear beats into the searchable stack under
// random idle and stall patterns, tracks a shadow stack to predict every
// result beat, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_tb;

  localparam int STACK_DEPTH = 64;
  localparam int TARGET_OPS  = 1150;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lss_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lss_pkg::out_t out_data;

  lifo_stack_with_search #(.DEPTH(STACK_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // shadow stack, entry 0 is the bottom
  logic [lss_pkg::WORD_W-1:0] shadow_words [STACK_DEPTH];
  int shadow_fill = 0;

  lss_pkg::in_t  pending_ops [$];
  lss_pkg::out_t predicted_replies [$];

  // generator-side view of what the stack holds, used to aim searches
  logic [lss_pkg::WORD_W-1:0] gen_words [$];
  int ops_queued = 0;

  int errors = 0;
  int idle_cycles = 0;
  int n_push = 0, n_pop = 0, n_search = 0, n_clear = 0;
  int n_full = 0, n_empty = 0, n_hit = 0, n_deep_hit = 0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int in_gap = 0, calm_in = 0;
  int out_hold = 0, calm_out = 0;

  // work out the result of one beat and update the shadow stack
  function automatic lss_pkg::out_t stack_predict(lss_pkg::in_t beat);
    lss_pkg::out_t r;
    int idx;
    r = '0;
    case (beat.mode)
      lss_pkg::MODE_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          r.status = lss_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_fill] = beat.value;
          shadow_fill++;
        end
      end
      lss_pkg::MODE_POP: begin
        if (shadow_fill == 0) r.status = lss_pkg::ST_EMPTY;
        else shadow_fill--;
      end
      lss_pkg::MODE_SEARCH: begin
        for (int k = 0; k < shadow_fill; k++) begin
          idx = shadow_fill - 1 - k;
          if (!r.found && shadow_words[idx] == beat.value) begin
            r.found = 1'b1;
            r.position = k[lss_pkg::POS_W-1:0];
          end
        end
      end
      default: shadow_fill = 0;
    endcase
    r.occupancy = shadow_fill[lss_pkg::OCC_W-1:0];
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [lss_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5, 6: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [1:0] mode, logic [lss_pkg::WORD_W-1:0] value);
    lss_pkg::in_t b;
    b.mode = mode;
    b.value = value;
    pending_ops.push_back(b);
    ops_queued++;
    case (mode)
      lss_pkg::MODE_PUSH: if (gen_words.size() < STACK_DEPTH) gen_words.push_back(value);
      lss_pkg::MODE_POP: if (gen_words.size() > 0) void'(gen_words.pop_back());
      lss_pkg::MODE_CLEAR: gen_words.delete();
      default: ;
    endcase
  endtask

  // search value: usually one that is held, at a random depth
  function automatic logic [lss_pkg::WORD_W-1:0] search_word();
    if (gen_words.size() > 0 && $urandom_range(0, 9) < 6)
      return gen_words[$urandom_range(0, gen_words.size() - 1)];
    return rand_word();
  endfunction

  task automatic fill_run();
    int extra;
    extra = $urandom_range(1, 3);
    while (gen_words.size() < STACK_DEPTH) queue_op(lss_pkg::MODE_PUSH, rand_word());
    repeat (extra) queue_op(lss_pkg::MODE_PUSH, rand_word());
    queue_op(lss_pkg::MODE_SEARCH, gen_words[0]);
    repeat ($urandom_range(1, 4)) queue_op(lss_pkg::MODE_SEARCH, search_word());
  endtask

  task automatic drain_run();
    int extra;
    extra = $urandom_range(1, 3);
    while (gen_words.size() > 0) begin
      if ($urandom_range(0, 4) == 0) queue_op(lss_pkg::MODE_SEARCH, search_word());
      queue_op(lss_pkg::MODE_POP, rand_word());
    end
    repeat (extra) queue_op(lss_pkg::MODE_POP, rand_word());
  endtask

  task automatic mixed_run();
    int r;
    repeat ($urandom_range(10, 30)) begin
      r = $urandom_range(0, 99);
      if (r < 38) queue_op(lss_pkg::MODE_PUSH, rand_word());
      else if (r < 58) queue_op(lss_pkg::MODE_POP, rand_word());
      else if (r < 96) queue_op(lss_pkg::MODE_SEARCH, search_word());
      else queue_op(lss_pkg::MODE_CLEAR, rand_word());
    end
  endtask

  // repeated small values so the nearest-top match matters
  task automatic dup_run();
    repeat ($urandom_range(6, 16)) begin
      if ($urandom_range(0, 2) == 0) queue_op(lss_pkg::MODE_SEARCH, $urandom_range(0, 4));
      else queue_op(lss_pkg::MODE_PUSH, $urandom_range(0, 3));
    end
  endtask

  // compare one result beat with its prediction
  task automatic check_reply(lss_pkg::out_t got, lss_pkg::out_t want);
    if (got.status !== want.status) begin
      errors++;
      $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status, got.status);
    end
    if (got.found !== want.found) begin
      errors++;
      $display("%0t: found mismatch, expected %0d actual %0d", $time, want.found, got.found);
    end
    if (got.position !== want.position) begin
      errors++;
      $display("%0t: position mismatch, expected %0d actual %0d",
               $time, want.position, got.position);
    end
    if (got.occupancy !== want.occupancy) begin
      errors++;
      $display("%0t: occupancy mismatch, expected %0d actual %0d",
               $time, want.occupancy, got.occupancy);
    end
  endtask

  // input driver: holds a beat until taken, then gap or next beat
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (pending_ops.size() > 0) begin
      in_data <= pending_ops.pop_front();
      in_valid <= 1'b1;
      if (calm_in > 0) begin
        calm_in--;
        in_gap = 0;
      end else begin
        in_gap = pick_gap();
        if ($urandom_range(0, 39) == 0) calm_in = 60;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
      if (out_taken) begin
        if (calm_out > 0) begin
          calm_out--;
        end else begin
          out_hold = pick_gap();
          if ($urandom_range(0, 39) == 0) calm_out = 60;
        end
      end
    end
  end

  // monitor: check result beats, then predict accepted input beats
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none actual %h", $time, out_data);
        end else begin
          check_reply(out_data, predicted_replies.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        lss_pkg::out_t p;
        p = stack_predict(in_data);
        predicted_replies.push_back(p);
        case (in_data.mode)
          lss_pkg::MODE_PUSH: n_push++;
          lss_pkg::MODE_POP: n_pop++;
          lss_pkg::MODE_SEARCH: n_search++;
          default: n_clear++;
        endcase
        if (p.status == lss_pkg::ST_FULL) n_full++;
        if (p.status == lss_pkg::ST_EMPTY) n_empty++;
        if (p.found) n_hit++;
        if (p.found && p.position == lss_pkg::POS_W'(STACK_DEPTH - 1)) n_deep_hit++;
      end
    end
  end

  // watchdog on cycles with outstanding work but no beat moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (pending_ops.size() > 0 || in_valid || predicted_replies.size() > 0) begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no beat moved for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    // directed beats: extremes, nearest-top match, empty cases, clear
    queue_op(lss_pkg::MODE_SEARCH, 32'h0000_0000);
    queue_op(lss_pkg::MODE_POP, 32'h0000_0000);
    queue_op(lss_pkg::MODE_PUSH, 32'h8000_0000);
    queue_op(lss_pkg::MODE_PUSH, 32'h7fff_ffff);
    queue_op(lss_pkg::MODE_PUSH, 32'h0000_0000);
    queue_op(lss_pkg::MODE_PUSH, 32'hffff_ffff);
    queue_op(lss_pkg::MODE_PUSH, 32'h0000_0005);
    queue_op(lss_pkg::MODE_PUSH, 32'h7fff_ffff);
    queue_op(lss_pkg::MODE_SEARCH, 32'h8000_0000);
    queue_op(lss_pkg::MODE_SEARCH, 32'h7fff_ffff);
    queue_op(lss_pkg::MODE_SEARCH, 32'hffff_ffff);
    queue_op(lss_pkg::MODE_SEARCH, 32'h0000_04d2);
    queue_op(lss_pkg::MODE_POP, 32'hffff_ffff);
    queue_op(lss_pkg::MODE_SEARCH, 32'h7fff_ffff);
    queue_op(lss_pkg::MODE_CLEAR, 32'h5555_5555);
    queue_op(lss_pkg::MODE_SEARCH, 32'h0000_0000);
    queue_op(lss_pkg::MODE_POP, 32'haaaa_aaaa);
    queue_op(lss_pkg::MODE_PUSH, 32'h5555_5555);
    queue_op(lss_pkg::MODE_PUSH, 32'haaaa_aaaa);
    queue_op(lss_pkg::MODE_SEARCH, 32'haaaa_aaaa);
    queue_op(lss_pkg::MODE_POP, 32'h0000_0000);
    queue_op(lss_pkg::MODE_POP, 32'h0000_0000);
    queue_op(lss_pkg::MODE_POP, 32'h0000_0000);
    fill_run();
    drain_run();

    // random runs of well-formed sequences plus noise
    while (ops_queued < TARGET_OPS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: mixed_run();
        9, 10, 11: fill_run();
        12, 13, 14: drain_run();
        15: queue_op(lss_pkg::MODE_CLEAR, rand_word());
        default: dup_run();
      endcase
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_ops.size() > 0 || in_valid || predicted_replies.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);

    if (predicted_replies.size() > 0) begin
      errors += predicted_replies.size();
      $display("%0t: %0d result beats never arrived", $time, predicted_replies.size());
    end

    $display("ran %0d push, %0d pop, %0d search, %0d clear beats", n_push, n_pop, n_search,
             n_clear);
    $display("%0d pushes on full, %0d pops on empty, %0d search hits (%0d at bottom)",
             n_full, n_empty, n_hit, n_deep_hit);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
